/* design/gbfp_pkg.sv */
// Shared constants and types for the binary frame parser.
package gbfp_pkg;

  localparam int BUF_BYTES    = 4096;
  localparam int HEADER_BYTES = 6;
  localparam int CHECK_BYTES  = 2;
  localparam int LEN_LIMIT    = BUF_BYTES - HEADER_BYTES - CHECK_BYTES;

  // Position, remaining count and held length: wide enough for a whole frame.
  localparam int CNT_W = $clog2(BUF_BYTES) + 1;
  localparam int OFF_W = 12;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [CNT_W-1:0] POS_HUNT   = CNT_W'(0);
  localparam logic [CNT_W-1:0] POS_SYNC2  = CNT_W'(1);
  localparam logic [CNT_W-1:0] POS_CLASS  = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_ID     = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_LEN_LO = CNT_W'(4);
  localparam logic [CNT_W-1:0] POS_LEN_HI = CNT_W'(5);
  localparam logic [CNT_W-1:0] POS_BODY   = CNT_W'(HEADER_BYTES);

  localparam logic [1:0] ROLE_DROP    = 2'd0;
  localparam logic [1:0] ROLE_HEADER  = 2'd1;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
  localparam logic [1:0] ROLE_CHECK   = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_SYNC     = 2'd1;
  localparam logic [1:0] ERR_LENGTH   = 2'd2;
  localparam logic [1:0] ERR_CHECKSUM = 2'd3;

  typedef struct packed {
    logic [7:0]       byte_value;
    logic [1:0]       byte_role;
    logic [OFF_W-1:0] payload_offset;
    logic             frame_end;
    logic             frame_good;
    logic [1:0]       error_code;
    logic [7:0]       msg_class;
    logic [7:0]       msg_id;
    logic [OFF_W-1:0] payload_length;
  } result_t;

endpackage

/* design/gbfp_framer.sv */
// Frame state, running checksum and per-word result for the frame parser.
module gbfp_framer (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output gbfp_pkg::result_t   res
);

  localparam int CW = gbfp_pkg::CNT_W;

  logic [CW-1:0] byte_position, byte_position_next;
  logic [CW-1:0] bytes_remaining, bytes_remaining_next;
  logic [7:0]    class_reg, class_reg_next;
  logic [7:0]    id_reg, id_reg_next;
  logic [7:0]    length_low, length_low_next;
  logic [CW-1:0] length_reg, length_reg_next;
  logic [7:0]    sum_a, sum_a_next;
  logic [7:0]    sum_b, sum_b_next;
  logic [7:0]    received_sum_a, received_sum_a_next;

  logic [7:0]    add_a, add_b;
  logic [15:0]   full_len;
  logic [CW-1:0] rem_eff;
  logic          done;

  assign add_a    = sum_a + rx_byte;
  assign add_b    = sum_b + add_a;
  assign full_len = {rx_byte, length_low};

  always_comb begin
    byte_position_next  = byte_position;
    bytes_remaining_next = bytes_remaining;
    class_reg_next      = class_reg;
    id_reg_next         = id_reg;
    length_low_next     = length_low;
    length_reg_next     = length_reg;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    received_sum_a_next = received_sum_a;
    rem_eff             = bytes_remaining;
    done                = 1'b0;

    res.byte_value     = rx_byte;
    res.byte_role      = gbfp_pkg::ROLE_DROP;
    res.payload_offset = '0;
    res.frame_end      = 1'b0;
    res.frame_good     = 1'b0;
    res.error_code     = gbfp_pkg::ERR_NONE;

    case (byte_position)
      gbfp_pkg::POS_HUNT: begin
        if (rx_byte == gbfp_pkg::SYNC_FIRST) begin
          res.byte_role      = gbfp_pkg::ROLE_HEADER;
          byte_position_next = gbfp_pkg::POS_SYNC2;
        end
      end
      gbfp_pkg::POS_SYNC2: begin
        if (rx_byte == gbfp_pkg::SYNC_SECOND) begin
          res.byte_role      = gbfp_pkg::ROLE_HEADER;
          byte_position_next = gbfp_pkg::POS_CLASS;
        end else begin
          res.frame_end  = 1'b1;
          res.error_code = gbfp_pkg::ERR_SYNC;
          done           = 1'b1;
        end
      end
      gbfp_pkg::POS_CLASS: begin
        class_reg_next     = rx_byte;
        sum_a_next         = rx_byte;
        sum_b_next         = rx_byte;
        res.byte_role      = gbfp_pkg::ROLE_HEADER;
        byte_position_next = gbfp_pkg::POS_ID;
      end
      gbfp_pkg::POS_ID: begin
        id_reg_next        = rx_byte;
        sum_a_next         = add_a;
        sum_b_next         = add_b;
        res.byte_role      = gbfp_pkg::ROLE_HEADER;
        byte_position_next = gbfp_pkg::POS_LEN_LO;
      end
      gbfp_pkg::POS_LEN_LO: begin
        length_low_next    = rx_byte;
        sum_a_next         = add_a;
        sum_b_next         = add_b;
        res.byte_role      = gbfp_pkg::ROLE_HEADER;
        byte_position_next = gbfp_pkg::POS_LEN_HI;
      end
      gbfp_pkg::POS_LEN_HI: begin
        // saturate an oversized length one above the limit
        if (32'(full_len) > 32'(gbfp_pkg::LEN_LIMIT)) begin
          length_reg_next = CW'(gbfp_pkg::LEN_LIMIT + 1);
        end else begin
          length_reg_next = CW'(full_len);
        end
        sum_a_next         = add_a;
        sum_b_next         = add_b;
        res.byte_role      = gbfp_pkg::ROLE_HEADER;
        byte_position_next = gbfp_pkg::POS_BODY;
      end
      default: begin
        if (byte_position == gbfp_pkg::POS_BODY &&
            32'(length_reg) > 32'(gbfp_pkg::LEN_LIMIT)) begin
          // drop the word after an oversized length
          res.frame_end  = 1'b1;
          res.error_code = gbfp_pkg::ERR_LENGTH;
          done           = 1'b1;
        end else begin
          if (byte_position == gbfp_pkg::POS_BODY) begin
            rem_eff = length_reg + CW'(gbfp_pkg::CHECK_BYTES);
          end
          if (rem_eff > CW'(gbfp_pkg::CHECK_BYTES)) begin
            res.byte_role      = gbfp_pkg::ROLE_PAYLOAD;
            res.payload_offset = gbfp_pkg::OFF_W'(byte_position - gbfp_pkg::POS_BODY);
            sum_a_next         = add_a;
            sum_b_next         = add_b;
          end else if (rem_eff == CW'(gbfp_pkg::CHECK_BYTES)) begin
            res.byte_role       = gbfp_pkg::ROLE_CHECK;
            received_sum_a_next = rx_byte;
          end else begin
            res.byte_role = gbfp_pkg::ROLE_CHECK;
            res.frame_end = 1'b1;
            done          = 1'b1;
            if (received_sum_a == sum_a && rx_byte == sum_b) begin
              res.frame_good = 1'b1;
            end else begin
              res.error_code = gbfp_pkg::ERR_CHECKSUM;
            end
          end
          bytes_remaining_next = (rem_eff != '0) ? rem_eff - CW'(1) : rem_eff;
          byte_position_next   = byte_position + CW'(1);
        end
      end
    endcase

    // report the header as held after this word, before any clear
    res.msg_class      = class_reg_next;
    res.msg_id         = id_reg_next;
    res.payload_length = gbfp_pkg::OFF_W'(length_reg_next);
  end

  always_ff @(posedge clk) begin
    if (rst || (step && done)) begin
      byte_position   <= '0;
      bytes_remaining <= '0;
      class_reg       <= '0;
      id_reg          <= '0;
      length_low      <= '0;
      length_reg      <= '0;
      sum_a           <= '0;
      sum_b           <= '0;
      received_sum_a  <= '0;
    end else if (step) begin
      byte_position   <= byte_position_next;
      bytes_remaining <= bytes_remaining_next;
      class_reg       <= class_reg_next;
      id_reg          <= id_reg_next;
      length_low      <= length_low_next;
      length_reg      <= length_reg_next;
      sum_a           <= sum_a_next;
      sum_b           <= sum_b_next;
      received_sum_a  <= received_sum_a_next;
    end
  end

endmodule

/* design/gnss_binary_frame_parser.sv */
// Top level of the binary frame parser: input register, framer and result register.
//
// Input channel: in_valid, in_stall, rx_byte. A word is taken at a rising
// edge with in_valid high and in_stall low.
// Output channel: out_valid, out_stall and one port per result field; one
// result word leaves for every input word, in order.
// Each word is tagged with its role (dropped, header, payload, checksum), its
// payload offset and the frame status; the last checksum word carries the
// Fletcher check result.
// Path: a word that is taken sits in the input register; its result is loaded
// into the result register, and out_valid rises, when that register advances.
// Throughput: one word per cycle while the result register is not stalled; the
// framer state and the running checksum update once per word.
// Stall: the two registers advance together whenever the result register is
// empty or being taken; while out_stall holds a full result register, in_stall
// rises once the input register is full, and both payloads hold.
// Reset (rst, synchronous): both registers empty, framer hunting for sync with
// all header fields and checksum cleared.
module gnss_binary_frame_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    byte_value,
  output logic [1:0]                    byte_role,
  output logic [gbfp_pkg::OFF_W-1:0]    payload_offset,
  output logic                          frame_end,
  output logic                          frame_good,
  output logic [1:0]                    error_code,
  output logic [7:0]                    msg_class,
  output logic [7:0]                    msg_id,
  output logic [gbfp_pkg::OFF_W-1:0]    payload_length
);

  logic              in_full;
  logic [7:0]        in_byte;
  logic              advance;
  gbfp_pkg::result_t res_next;
  gbfp_pkg::result_t res;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;

  gbfp_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .step    (advance && in_full),
    .rx_byte (in_byte),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_full <= in_valid;
      end
      if (advance) begin
        out_valid <= in_full;
      end
    end
  end

  // payload registers: load when their valid flags load with a valid word, else hold
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte <= rx_byte;
    end
    if (advance && in_full) begin
      res <= res_next;
    end
  end

  assign byte_value     = res.byte_value;
  assign byte_role      = res.byte_role;
  assign payload_offset = res.payload_offset;
  assign frame_end      = res.frame_end;
  assign frame_good     = res.frame_good;
  assign error_code     = res.error_code;
  assign msg_class      = res.msg_class;
  assign msg_id         = res.msg_id;
  assign payload_length = res.payload_length;

endmodule
